// File: src/pda_pkg.sv
package pda_pkg;

	// default depth of the request queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// nibble codes
	localparam logic [3:0] NIB_DIGIT_MAX = 4'd9;
	localparam logic [3:0] NIB_DOT = 4'd10;
	localparam logic [3:0] NIB_RUN_FIRST = 4'd11;
	localparam logic [3:0] NIB_RUN_LAST = 4'd14;
	localparam logic [3:0] NIB_END = 4'd15;
	localparam logic [3:0] NIB_RUN_BIAS = 4'd10;

	// characters
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_E = 8'h45;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_F = 8'h46;

	localparam logic [7:0] BYTE_ZERO_A = 8'h0F;
	localparam logic [7:0] BYTE_ZERO_B = 8'hFF;

	// request kinds: explicit items or one of the fixed texts
	typedef enum logic [2:0] {
		KIND_ITEMS,
		KIND_ZERO,
		KIND_ERR,
		KIND_NINF,
		KIND_INF
	} kind_t;

	typedef struct packed {
		logic [7:0]  ch;
		logic [15:0] cnt;
		logic        last;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  n_items;
		item_t       item0;
		item_t       item1;
	} cmd_t;

endpackage

// File: src/pda_front.sv
module pda_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	input  logic [7:0]      packed_byte,
	input  logic            q_full,
	output logic            byte_stall,
	output logic            push,
	output pda_pkg::cmd_t   push_cmd
);

	typedef struct packed {
		logic        at_first;
		logic [3:0]  run_mode;
		logic [2:0]  left;
		logic [3:0]  run_value;
		logic        taken;
		logic [15:0] acc;
	} fstate_t;

	typedef struct packed {
		fstate_t         st;
		logic            emit;
		pda_pkg::item_t  item;
		logic            ended;
	} nib_res_t;

	// one nibble of the number
	function automatic nib_res_t nib_step(fstate_t s, logic [3:0] n);
		nib_res_t    r;
		logic [15:0] acc_n;
		logic [2:0]  left_n;
		r = '0;
		r.st = s;
		acc_n = {s.acc[11:0], n};
		left_n = s.left - 3'd1;
		if (s.run_mode != 4'd0) begin
			if (!s.taken) begin
				r.st.run_value = n;
				r.st.taken = 1'b1;
			end else begin
				r.st.acc = acc_n;
				r.st.left = left_n;
				if (left_n == 3'd0) begin
					if (acc_n != 16'd0) begin
						r.emit = 1'b1;
						r.item.ch = pda_pkg::ASCII_ZERO + {4'd0, s.run_value};
						r.item.cnt = acc_n;
						r.item.last = 1'b0;
					end
					r.st.run_mode = 4'd0;
					r.st.run_value = 4'd0;
					r.st.taken = 1'b0;
					r.st.acc = 16'd0;
				end
			end
		end else if (n <= pda_pkg::NIB_DIGIT_MAX) begin
			r.emit = 1'b1;
			r.item.ch = pda_pkg::ASCII_ZERO + {4'd0, n};
			r.item.cnt = 16'd1;
		end else if (n == pda_pkg::NIB_DOT) begin
			r.emit = 1'b1;
			r.item.ch = pda_pkg::CH_DOT;
			r.item.cnt = 16'd1;
		end else if (n >= pda_pkg::NIB_RUN_FIRST && n <= pda_pkg::NIB_RUN_LAST) begin
			r.st.run_mode = n;
			r.st.left = 3'(n - pda_pkg::NIB_RUN_BIAS);
			r.st.run_value = 4'd0;
			r.st.taken = 1'b0;
			r.st.acc = 16'd0;
		end else begin
			r.emit = 1'b1;
			r.item.ch = pda_pkg::CH_NUL;
			r.item.cnt = 16'd1;
			r.item.last = 1'b1;
			r.st.at_first = 1'b1;
			r.ended = 1'b1;
		end
		return r;
	endfunction

	fstate_t       st_q;
	fstate_t       st_norm;
	fstate_t       st_next;
	nib_res_t      r_hi;
	nib_res_t      r_lo;
	nib_res_t      r_neg;
	logic [3:0]    hi;
	logic [3:0]    lo;
	logic          accept;
	logic          has_req;
	pda_pkg::cmd_t cmd;

	assign hi = packed_byte[7:4];
	assign lo = packed_byte[3:0];
	assign byte_stall = q_full;
	assign accept = byte_valid && !q_full;

	// state seen by the nibble path; a first byte opens with no run
	always_comb begin
		st_norm = st_q;
		if (st_q.at_first) begin
			st_norm.at_first = 1'b0;
			st_norm.run_mode = 4'd0;
		end
	end

	assign r_hi = nib_step(st_norm, hi);
	assign r_lo = nib_step(r_hi.st, lo);
	assign r_neg = nib_step(st_norm, lo);

	// classify the byte and build the request
	always_comb begin
		cmd = '0;
		cmd.kind = pda_pkg::KIND_ITEMS;
		has_req = 1'b0;
		st_next = st_q;
		if (st_q.at_first && (packed_byte == pda_pkg::BYTE_ZERO_A ||
				packed_byte == pda_pkg::BYTE_ZERO_B)) begin
			cmd.kind = pda_pkg::KIND_ZERO;
			has_req = 1'b1;
		end else if (st_q.at_first && hi >= pda_pkg::NIB_RUN_FIRST &&
				hi <= pda_pkg::NIB_RUN_LAST && lo > pda_pkg::NIB_DIGIT_MAX) begin
			cmd.kind = pda_pkg::KIND_ERR;
			has_req = 1'b1;
		end else if (st_q.at_first && hi == pda_pkg::NIB_END) begin
			if (lo == 4'd0) begin
				cmd.kind = pda_pkg::KIND_NINF;
				has_req = 1'b1;
			end else begin
				// minus sign, then the low nibble as usual
				cmd.item0.ch = pda_pkg::CH_MINUS;
				cmd.item0.cnt = 16'd1;
				cmd.item0.last = 1'b0;
				cmd.item1 = r_neg.item;
				cmd.n_items = r_neg.emit ? 2'd2 : 2'd1;
				has_req = 1'b1;
				st_next = r_neg.st;
			end
		end else if (st_q.at_first && (hi == 4'd0 || lo == 4'd0)) begin
			cmd.kind = pda_pkg::KIND_INF;
			has_req = 1'b1;
		end else begin
			// ordinary byte: high nibble, then low unless the number ended
			if (r_hi.ended) begin
				st_next = r_hi.st;
				cmd.item0 = r_hi.item;
				cmd.n_items = 2'd1;
			end else begin
				st_next = r_lo.st;
				cmd.item0 = r_hi.emit ? r_hi.item : r_lo.item;
				cmd.item1 = r_lo.item;
				cmd.n_items = {1'b0, r_hi.emit} + {1'b0, r_lo.emit};
			end
			has_req = cmd.n_items != 2'd0;
		end
	end

	assign push = accept && has_req;
	assign push_cmd = cmd;

	// number state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{at_first: 1'b1, run_mode: 4'd0, left: 3'd0, run_value: 4'd0,
				taken: 1'b0, acc: 16'd0};
		end else if (accept) begin
			st_q <= st_next;
		end
	end

endmodule

// File: src/pda_queue.sv
module pda_queue #(
	parameter int DEPTH = pda_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pda_pkg::cmd_t   push_cmd,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output pda_pkg::cmd_t   head_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pda_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = count_q == CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("request queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("request queue underflow");
`endif

endmodule

// File: src/pda_back.sv
module pda_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  pda_pkg::cmd_t   head_cmd,
	output logic            pop,
	input  logic            char_stall,
	output logic            char_valid,
	output logic [7:0]      out_char,
	output logic [15:0]     repeat_count,
	output logic            end_of_number
);

	// number of result items a request expands to
	function automatic logic [2:0] cmd_len(pda_pkg::cmd_t c);
		logic [2:0] n;
		case (c.kind)
			pda_pkg::KIND_ZERO: n = 3'd2;
			pda_pkg::KIND_ERR:  n = 3'd4;
			pda_pkg::KIND_NINF: n = 3'd5;
			pda_pkg::KIND_INF:  n = 3'd4;
			default:            n = {1'b0, c.n_items};
		endcase
		return n;
	endfunction

	// character of a fixed text at a position; NUL past the letters
	function automatic logic [7:0] text_char(pda_pkg::kind_t k, logic [2:0] i);
		logic [7:0] ch;
		ch = pda_pkg::CH_NUL;
		case (k)
			pda_pkg::KIND_ZERO: begin
				if (i == 3'd0) ch = pda_pkg::ASCII_ZERO;
			end
			pda_pkg::KIND_ERR: begin
				if (i == 3'd0) ch = pda_pkg::CH_E;
				else if (i == 3'd1 || i == 3'd2) ch = pda_pkg::CH_R;
			end
			pda_pkg::KIND_NINF: begin
				if (i == 3'd0) ch = pda_pkg::CH_MINUS;
				else if (i == 3'd1) ch = pda_pkg::CH_I;
				else if (i == 3'd2) ch = pda_pkg::CH_N;
				else if (i == 3'd3) ch = pda_pkg::CH_F;
			end
			pda_pkg::KIND_INF: begin
				if (i == 3'd0) ch = pda_pkg::CH_I;
				else if (i == 3'd1) ch = pda_pkg::CH_N;
				else if (i == 3'd2) ch = pda_pkg::CH_F;
			end
			default: ch = pda_pkg::CH_NUL;
		endcase
		return ch;
	endfunction

	pda_pkg::cmd_t  cmd_q;
	logic           cmd_valid_q;
	logic [2:0]     idx_q;
	logic [2:0]     cur_len;
	logic           out_ready;
	logic           adv;
	logic           fin;
	pda_pkg::item_t cur_item;

	assign cur_len = cmd_len(cmd_q);
	assign out_ready = !char_valid || !char_stall;
	assign adv = cmd_valid_q && out_ready;
	assign fin = adv && (idx_q == cur_len - 3'd1);
	assign pop = head_valid && (!cmd_valid_q || fin);

	// item at the current position
	always_comb begin
		if (cmd_q.kind == pda_pkg::KIND_ITEMS) begin
			cur_item = (idx_q == 3'd0) ? cmd_q.item0 : cmd_q.item1;
		end else begin
			cur_item.ch = text_char(cmd_q.kind, idx_q);
			cur_item.cnt = 16'd1;
			cur_item.last = idx_q == cur_len - 3'd1;
		end
	end

	// request being expanded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
			idx_q <= 3'd0;
		end else if (pop) begin
			cmd_valid_q <= 1'b1;
			idx_q <= 3'd0;
		end else if (fin) begin
			cmd_valid_q <= 1'b0;
			idx_q <= 3'd0;
		end else if (adv) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head_cmd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
		end else if (out_ready) begin
			char_valid <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_char <= cur_item.ch;
			repeat_count <= cur_item.cnt;
			end_of_number <= cur_item.last;
		end
	end

`ifndef ASSERT_OFF
	a_end_is_nul: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && end_of_number) |-> (out_char == pda_pkg::CH_NUL))
		else $error("end of number on a non-NUL character");
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (repeat_count != 16'd0))
		else $error("result with zero repeat count");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid_q |-> (idx_q < cur_len))
		else $error("expansion position past request length");
`endif

endmodule

// File: src/packed_decimal_to_ascii_top.sv
// a byte runs through the queue, then the back end's request and output registers
// throughput: one byte per cycle while the request queue has room; one result per cycle
// a byte gives zero to two results, a special first byte two to five; the single
// output register of the back end paces the results; char_stall can hold it
// reset: asynchronous, clears the queue and the run state; the block then awaits
// the first byte of a number
module packed_decimal_to_ascii_top #(
	parameter int QUEUE_DEPTH = pda_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  packed_byte,
	output logic        char_valid,
	input  logic        char_stall,
	output logic [7:0]  out_char,
	output logic [15:0] repeat_count,
	output logic        end_of_number
);

	logic          q_full;
	logic          push;
	pda_pkg::cmd_t push_cmd;
	logic          pop;
	logic          head_valid;
	pda_pkg::cmd_t head_cmd;

	// byte classification and number state
	pda_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.packed_byte (packed_byte),
		.q_full      (q_full),
		.byte_stall  (byte_stall),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	// request queue
	pda_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// expansion into result items
	pda_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_cmd      (head_cmd),
		.pop           (pop),
		.char_stall    (char_stall),
		.char_valid    (char_valid),
		.out_char      (out_char),
		.repeat_count  (repeat_count),
		.end_of_number (end_of_number)
	);

endmodule

// File: bench/packed_decimal_to_ascii_top_tb.sv
`timescale 1ns / 1ps

module packed_decimal_to_ascii_top_tb;

	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int BYTE_TARGET = 210;

	// directed bytes, grouped by the case they reach
	localparam int DIRECTED_LEN = 26;
	localparam logic [7:0] DIRECTED_BYTES [DIRECTED_LEN] = '{
		8'h0F, 8'hFF,               // both zero forms
		8'hCB, 8'hEF,               // bad pack bytes
		8'hF0,                      // negative infinity
		8'h05, 8'h50,               // infinity from a zero nibble
		8'hFA, 8'h12, 8'h3F,        // negative number starting with a dot
		8'h12, 8'hA9, 8'hF7,        // digits and dot, early end drops the low nibble
		8'h1B, 8'hF3, 8'hF8,        // run value of fifteen, count three
		8'h9C, 8'h50, 8'h0F,        // run with a zero count
		8'h3E, 8'h7F, 8'hFF, 8'hFF, // four count nibbles, code 15 as data
		8'hFB, 8'h21, 8'hF0         // negative number with a run in the low nibble
	};

	typedef struct {
		logic [7:0] value;
		bit         drain;
	} pending_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_ALTERNATE,
		STALL_RANDOM,
		STALL_BLOCKS
	} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  packed_byte = 8'h00;
	logic        char_valid;
	logic        char_stall = 1'b0;
	logic [7:0]  out_char;
	logic [15:0] repeat_count;
	logic        end_of_number;

	packed_decimal_to_ascii_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.packed_byte   (packed_byte),
		.char_valid    (char_valid),
		.char_stall    (char_stall),
		.out_char      (out_char),
		.repeat_count  (repeat_count),
		.end_of_number (end_of_number)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// converter state as the bench sees it
	logic        await_first;
	logic [3:0]  run_code;
	logic [2:0]  count_left;
	logic [3:0]  run_char;
	logic        run_char_seen;
	logic [15:0] run_count;

	pda_pkg::item_t expected_chars[$];
	pending_t       pending_bytes[$];
	int             chars_owed = 0;
	int             fail_count = 0;

	task automatic push_char(input logic [7:0] ch, input logic [15:0] cnt,
			input logic last);
		pda_pkg::item_t entry;
		entry.ch = ch;
		entry.cnt = cnt;
		entry.last = last;
		expected_chars.push_back(entry);
	endtask

	// fixed texts followed by the terminating nul
	task automatic push_fixed_text(input pda_pkg::kind_t kind);
		case (kind)
			pda_pkg::KIND_ZERO: begin
				push_char(pda_pkg::ASCII_ZERO, 16'd1, 1'b0);
			end
			pda_pkg::KIND_ERR: begin
				push_char(pda_pkg::CH_E, 16'd1, 1'b0);
				push_char(pda_pkg::CH_R, 16'd1, 1'b0);
				push_char(pda_pkg::CH_R, 16'd1, 1'b0);
			end
			pda_pkg::KIND_NINF: begin
				push_char(pda_pkg::CH_MINUS, 16'd1, 1'b0);
				push_char(pda_pkg::CH_I, 16'd1, 1'b0);
				push_char(pda_pkg::CH_N, 16'd1, 1'b0);
				push_char(pda_pkg::CH_F, 16'd1, 1'b0);
			end
			pda_pkg::KIND_INF: begin
				push_char(pda_pkg::CH_I, 16'd1, 1'b0);
				push_char(pda_pkg::CH_N, 16'd1, 1'b0);
				push_char(pda_pkg::CH_F, 16'd1, 1'b0);
			end
			default: begin
			end
		endcase
		push_char(pda_pkg::CH_NUL, 16'd1, 1'b1);
	endtask

	// one nibble of a number; ended goes high when the number closes
	task automatic take_nibble(input logic [3:0] n, output logic ended);
		ended = 1'b0;
		if (run_code != 4'd0) begin
			if (!run_char_seen) begin
				run_char = n;
				run_char_seen = 1'b1;
			end else begin
				run_count = {run_count[11:0], n};
				count_left = count_left - 3'd1;
				if (count_left == 3'd0) begin
					if (run_count != 16'd0)
						push_char(pda_pkg::ASCII_ZERO + {4'd0, run_char}, run_count, 1'b0);
					run_code = 4'd0;
					run_char = 4'd0;
					run_char_seen = 1'b0;
					run_count = 16'd0;
				end
			end
		end else if (n <= pda_pkg::NIB_DIGIT_MAX) begin
			push_char(pda_pkg::ASCII_ZERO + {4'd0, n}, 16'd1, 1'b0);
		end else if (n == pda_pkg::NIB_DOT) begin
			push_char(pda_pkg::CH_DOT, 16'd1, 1'b0);
		end else if (n >= pda_pkg::NIB_RUN_FIRST && n <= pda_pkg::NIB_RUN_LAST) begin
			run_code = n;
			count_left = 3'(n - pda_pkg::NIB_RUN_BIAS);
			run_char = 4'd0;
			run_char_seen = 1'b0;
			run_count = 16'd0;
		end else begin
			push_char(pda_pkg::CH_NUL, 16'd1, 1'b1);
			await_first = 1'b1;
			ended = 1'b1;
		end
	endtask

	task automatic predict_byte(input logic [7:0] b);
		logic [3:0] hi;
		logic [3:0] lo;
		logic       handled;
		logic       ended;
		hi = b[7:4];
		lo = b[3:0];
		handled = 1'b0;
		ended = 1'b0;
		// first byte screens the special forms
		if (await_first) begin
			if (b == pda_pkg::BYTE_ZERO_A || b == pda_pkg::BYTE_ZERO_B) begin
				push_fixed_text(pda_pkg::KIND_ZERO);
				handled = 1'b1;
			end else if (hi >= pda_pkg::NIB_RUN_FIRST && hi <= pda_pkg::NIB_RUN_LAST &&
					lo > pda_pkg::NIB_DIGIT_MAX) begin
				push_fixed_text(pda_pkg::KIND_ERR);
				handled = 1'b1;
			end else if (hi == pda_pkg::NIB_END) begin
				if (lo == 4'd0) begin
					push_fixed_text(pda_pkg::KIND_NINF);
				end else begin
					await_first = 1'b0;
					run_code = 4'd0;
					push_char(pda_pkg::CH_MINUS, 16'd1, 1'b0);
					take_nibble(lo, ended);
				end
				handled = 1'b1;
			end else if (hi == 4'd0 || lo == 4'd0) begin
				push_fixed_text(pda_pkg::KIND_INF);
				handled = 1'b1;
			end else begin
				await_first = 1'b0;
				run_code = 4'd0;
			end
		end
		if (!handled) begin
			take_nibble(hi, ended);
			if (!ended)
				take_nibble(lo, ended);
		end
	endtask

	task automatic queue_byte(input logic [7:0] b, input bit drain);
		pending_t entry;
		entry.value = b;
		entry.drain = drain;
		pending_bytes.push_back(entry);
	endtask

	function automatic logic [3:0] rand_nib(input int lo, input int hi);
		return 4'($urandom_range(hi, lo));
	endfunction

	// well-formed number with random content; first byte never a special form
	task automatic add_number(input bit drain_first);
		logic [3:0] nibs[$];
		logic [3:0] opener;
		bit         negative;
		bit         opens;
		int         i;
		opens = 1'b0;
		while (!opens) begin
			nibs.delete();
			negative = ($urandom_range(0, 3) == 0);
			if (negative)
				nibs.push_back(pda_pkg::NIB_END);
			repeat ($urandom_range(1, 7)) begin
				case ($urandom_range(0, 5))
					0, 1, 2: nibs.push_back(rand_nib(0, 9));
					3: nibs.push_back(pda_pkg::NIB_DOT);
					default: begin
						opener = rand_nib(pda_pkg::NIB_RUN_FIRST, pda_pkg::NIB_RUN_LAST);
						nibs.push_back(opener);
						nibs.push_back(rand_nib(0, 15));
						// zero count nibbles are common so empty runs show up
						repeat (opener - pda_pkg::NIB_RUN_BIAS)
							nibs.push_back($urandom_range(0, 1) ? rand_nib(0, 15) : 4'd0);
					end
				endcase
			end
			nibs.push_back(pda_pkg::NIB_END);
			if (nibs.size() % 2 != 0)
				nibs.push_back(rand_nib(0, 15));
			if (negative)
				opens = (nibs[1] != 4'd0);
			else
				opens = nibs[0] != 4'd0 && nibs[1] != 4'd0 &&
					!(nibs[0] >= pda_pkg::NIB_RUN_FIRST && nibs[1] > pda_pkg::NIB_DIGIT_MAX);
		end
		for (i = 0; i < nibs.size(); i += 2)
			queue_byte({nibs[i], nibs[i + 1]},
				i == 0 && (drain_first || $urandom_range(0, 29) == 0));
	endtask

	// sender: bursts with gaps; a drain request waits for every result
	int       gap_left = 0;
	int       burst_left = 0;
	pending_t next_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			packed_byte <= 8'h00;
			gap_left = 0;
			burst_left = 0;
		end else if (!(byte_valid && byte_stall)) begin
			if (gap_left != 0) begin
				gap_left = gap_left - 1;
				byte_valid <= 1'b0;
			end else if (pending_bytes.size() != 0 &&
					(!pending_bytes[0].drain || (!byte_valid && chars_owed == 0))) begin
				next_req = pending_bytes.pop_front();
				byte_valid <= 1'b1;
				packed_byte <= next_req.value;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 16);
					if ($urandom_range(0, 9) == 0)
						gap_left = $urandom_range(10, 25);
					else if ($urandom_range(0, 2) == 0)
						gap_left = 0;
					else
						gap_left = $urandom_range(1, 6);
				end else begin
					burst_left = burst_left - 1;
				end
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// receiver: stalls follow a pattern that is drawn anew at random, one of four modes
	int          rx_cycle = 0;
	stall_mode_t stall_mode = STALL_NONE;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_stall <= 1'b0;
			rx_cycle = 0;
			stall_mode = STALL_NONE;
		end else begin
			rx_cycle = rx_cycle + 1;
			if (rx_cycle % 96 == 0)
				stall_mode = stall_mode_t'($urandom_range(0, 3));
			case (stall_mode)
				STALL_NONE: char_stall <= 1'b0;
				STALL_ALTERNATE: char_stall <= rx_cycle[0];
				STALL_RANDOM: char_stall <= ($urandom_range(0, 2) == 0);
				default: char_stall <= (rx_cycle[3:2] == 2'b11);
			endcase
		end
	end

	// monitor: predict on each accepted request, then check each result
	pda_pkg::item_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall)
				predict_byte(packed_byte);
			if (char_valid && !char_stall) begin
				if (expected_chars.size() == 0) begin
					$error("unexpected result: out_char %h, repeat_count %0d, end_of_number %b",
						out_char, repeat_count, end_of_number);
					fail_count++;
				end else begin
					want = expected_chars.pop_front();
					if (out_char !== want.ch) begin
						$error("out_char: expected %h, got %h", want.ch, out_char);
						fail_count++;
					end
					if (repeat_count !== want.cnt) begin
						$error("repeat_count: expected %0d, got %0d", want.cnt, repeat_count);
						fail_count++;
					end
					if (end_of_number !== want.last) begin
						$error("end_of_number: expected %b, got %b", want.last, end_of_number);
						fail_count++;
					end
				end
			end
			chars_owed <= expected_chars.size();
		end
	end

	// watchdog on cycles with no handshake on either side
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (char_valid && !char_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus, reset and end of run
	initial begin
		await_first = 1'b1;
		run_code = 4'd0;
		count_left = 3'd0;
		run_char = 4'd0;
		run_char_seen = 1'b0;
		run_count = 16'd0;

		foreach (DIRECTED_BYTES[i])
			queue_byte(DIRECTED_BYTES[i], 1'b0);
		// first random number waits for the directed results to drain
		add_number(1'b1);
		while (pending_bytes.size() < BYTE_TARGET) begin
			if ($urandom_range(0, 9) < 8)
				add_number(1'b0);
			else
				repeat ($urandom_range(1, 3))
					queue_byte(8'($urandom_range(0, 255)), 1'b0);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || byte_valid || expected_chars.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0 && expected_chars.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
